// File: design/asf_pkg.sv
// Shared types, constants and tables of the arrive steering force block.
package asf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES = 24;

   // pipeline depth from accepted item to result strobe
   localparam int LATENCY = 139;

   // CORDIC datapath widths
   localparam int CX_W = 36;
   localparam int CZ_W = 34;

   localparam logic [30:0] BRAKE_RADIUS_RST = 31'd6553600;
   localparam logic [30:0] STOP_RADIUS_RST = 31'd655360;
   localparam logic [30:0] BRAKE_FACTOR_RST = 31'd65536;

   // angles in Q29 radians
   localparam logic [31:0] PI_Q29 = 32'd1686629713;
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   // 2pi * 2^14, keeps the angle difference positive before reduction
   localparam logic [47:0] MOD_BIAS = 48'(TWO_PI_Q29) << 14;
   localparam logic signed [33:0] TURN_MAX = 34'sd25736;

   localparam logic [31:0] ATAN_Q29 [ATAN_ENTRIES] = '{
      32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579, 32'd33510830,
      32'd16771758, 32'd8387925, 32'd4194219, 32'd2097141, 32'd1048575,
      32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384,
      32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64
   };

   typedef enum logic [1:0] {
      CSR_BRAKE_RADIUS = 2'd0,
      CSR_STOP_RADIUS  = 2'd1,
      CSR_BRAKE_FACTOR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [34:0] rem;
      logic [31:0] root;
   } sqrt_type;

endpackage

// File: design/asf_delay.sv
// Fixed-depth shift line that carries side data alongside a cell row.
module asf_delay #(
   parameter int W = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// File: design/asf_sqrt_cell.sv
// One root digit of the integer square root row.
module asf_sqrt_cell import asf_pkg::*; (
   input  logic     clock,
   input  sqrt_type sq_in,
   output sqrt_type sq_out
);

   sqrt_type   sq_ff;
   sqrt_type   sq_in_nxt;
   logic [34:0] r2;
   logic [34:0] trial;
   logic        ge;

   always_comb begin
      r2 = {sq_in.rem[32:0], sq_in.rad[63:62]};
      trial = {1'b0, sq_in.root, 2'b01};
      ge = (r2 >= trial);
      sq_in_nxt.rem = ge ? (r2 - trial) : r2;
      sq_in_nxt.root = {sq_in.root[30:0], ge};
      sq_in_nxt.rad = {sq_in.rad[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in_nxt;
   end

   assign sq_out = sq_ff;

endmodule

// File: design/asf_cordic_cell.sv
// One CORDIC vectoring rotation with a fixed shift.
module asf_cordic_cell import asf_pkg::*; #(
   parameter int K = 0
) (
   input  logic       clock,
   input  cordic_type cor_in,
   output cordic_type cor_out
);

   localparam logic signed [CZ_W-1:0] ANG = CZ_W'(ATAN_Q29[K]);

   cordic_type             cor_ff;
   cordic_type             cor_nxt;
   logic signed [CX_W-1:0] xs;
   logic signed [CX_W-1:0] ys;
   logic                   pos;

   always_comb begin
      xs = $signed(cor_in.x) >>> K;
      ys = $signed(cor_in.y) >>> K;
      pos = !cor_in.y[CX_W-1] && (cor_in.y != '0);
      if (pos) begin
         cor_nxt.x = cor_in.x + ys;
         cor_nxt.y = cor_in.y - xs;
         cor_nxt.z = cor_in.z + ANG;
      end else begin
         cor_nxt.x = cor_in.x - ys;
         cor_nxt.y = cor_in.y + xs;
         cor_nxt.z = cor_in.z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      cor_ff <= cor_nxt;
   end

   assign cor_out = cor_ff;

endmodule

// File: design/asf_div_cell.sv
// One quotient bit of a restoring divider row.
module asf_div_cell #(
   parameter int RW = 64,
   parameter int DW = 32,
   parameter int QW = 32,
   parameter int K = 0
) (
   input  logic          clock,
   input  logic [RW-1:0] rem_in,
   input  logic [DW-1:0] den_in,
   input  logic [QW-1:0] quot_in,
   output logic [RW-1:0] rem_out,
   output logic [DW-1:0] den_out,
   output logic [QW-1:0] quot_out
);

   logic [RW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] quot_ff;
   logic [RW-1:0] sub_den;
   logic [RW:0]   trial;
   logic          qbit;

   always_comb begin
      sub_den = RW'(den_in) << K;
      trial = {1'b0, rem_in} - {1'b0, sub_den};
      qbit = !trial[RW];
   end

   always_ff @(posedge clock) begin
      rem_ff <= qbit ? trial[RW-1:0] : rem_in;
      den_ff <= den_in;
      quot_ff <= {quot_in[QW-2:0], qbit};
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quot_out = quot_ff;

endmodule

// File: design/arrive_steering_force.sv
// Arrive steering force: fully pipelined rows of cells, one agent item per clock.
//
// Usage: an item is taken on every clock edge with start high (busy is always low),
// and its result appears on the rsp_ ports for one cycle, flagged by rsp_valid;
// the receiver cannot stall, so it must sample every strobe. Throughput is one
// item per cycle. The latency comes from the cell rows in series: the 32-cell
// square root row, the 31-cell wanted-speed divider, the 32-cell component
// divider and the 32-cell force divider, each cell resolving one bit. The heading
// angle runs in a CORDIC row of CORDIC_STEPS cells beside the root, then a 16-cell
// modulo-2pi row; total latency does not depend on CORDIC_STEPS. The csr_
// registers feed the pipeline live, so write them only with no item in flight.
module arrive_steering_force import asf_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_heading,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic [30:0]        req_max_force,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [15:0] rsp_turn_force,
   output logic               rsp_stopped,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wdata
);

   // the angle leaves the CORDIC row at stage CORDIC_STEPS+2, the root at stage 36
   localparam int ZDLY = 34 - CORDIC_STEPS;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [31:0] head;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [30:0]        mf;
   } side_a_type;

   typedef struct packed {
      logic               want_big;
      logic               stopped;
      logic               zero;
      logic               sx;
      logic               sy;
      logic [30:0]        mf;
      logic [31:0]        magx;
      logic [31:0]        magy;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [32:0]        dlen;
   } side_c_type;

   typedef struct packed {
      logic               sx;
      logic               sy;
      logic               zero;
      logic               stopped;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } side_d_type;

   typedef struct packed {
      logic negx;
      logic negy;
      logic ovfx;
      logic ovfy;
      logic stopped;
   } side_e_type;

   // saturate a sign and 32-bit magnitude quotient to signed 32 bits
   function automatic logic [31:0] sat_force(input logic neg, input logic ovf,
                                             input logic [31:0] q);
      logic [31:0] res;
      if (neg) begin
         if (ovf || (q > 32'h8000_0000)) begin
            res = 32'h8000_0000;
         end else begin
            res = -q;
         end
      end else begin
         if (ovf || q[31]) begin
            res = 32'h7FFF_FFFF;
         end else begin
            res = q;
         end
      end
      return res;
   endfunction

   // ---------------- configuration registers ----------------
   logic [30:0] br_ff;
   logic [30:0] sr_ff;
   logic [30:0] bf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         br_ff <= BRAKE_RADIUS_RST;
         sr_ff <= STOP_RADIUS_RST;
         bf_ff <= BRAKE_FACTOR_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BRAKE_RADIUS: br_ff <= csr_wdata;
            CSR_STOP_RADIUS:  sr_ff <= csr_wdata;
            CSR_BRAKE_FACTOR: bf_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- item tags ----------------
   logic acc;
   logic vld_ff [LATENCY];

   assign busy = 1'b0;
   assign acc = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= acc;
         for (int i = 1; i < LATENCY; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];

   // ---------------- stage 1: offsets ----------------
   side_a_type s1_ff;

   always_ff @(posedge clock) begin
      s1_ff.dx <= {req_target_x[31], req_target_x} - {req_pos_x[31], req_pos_x};
      s1_ff.dy <= {req_target_y[31], req_target_y} - {req_pos_y[31], req_pos_y};
      s1_ff.head <= req_heading;
      s1_ff.vx <= req_vel_x;
      s1_ff.vy <= req_vel_y;
      s1_ff.mf <= req_max_force;
   end

   // ---------------- stage 2: magnitudes, range shift, CORDIC pre-rotation ----------------
   logic [32:0]            ax1;
   logic [32:0]            ay1;
   logic                   sh1;
   logic signed [CX_W-1:0] dxe1;
   logic signed [CX_W-1:0] dye1;
   logic [30:0]            s2_ax_ff;
   logic [30:0]            s2_ay_ff;
   logic                   s2_sh_ff;
   cordic_type             s2_cor_ff;

   always_comb begin
      ax1 = s1_ff.dx[32] ? (33'd0 - s1_ff.dx) : s1_ff.dx;
      ay1 = s1_ff.dy[32] ? (33'd0 - s1_ff.dy) : s1_ff.dy;
      // halve both when either reaches 2^31 so the sum of squares fits
      sh1 = ax1[31] | ay1[31];
      dxe1 = $signed({{(CX_W-33){s1_ff.dx[32]}}, s1_ff.dx});
      dye1 = $signed({{(CX_W-33){s1_ff.dy[32]}}, s1_ff.dy});
   end

   always_ff @(posedge clock) begin
      s2_ax_ff <= sh1 ? ax1[31:1] : ax1[30:0];
      s2_ay_ff <= sh1 ? ay1[31:1] : ay1[30:0];
      s2_sh_ff <= sh1;
      // left half-plane: flip the vector and start from +-pi
      if (s1_ff.dx[32]) begin
         s2_cor_ff.x <= -dxe1;
         s2_cor_ff.y <= -dye1;
         s2_cor_ff.z <= s1_ff.dy[32] ? -$signed({2'b00, PI_Q29}) : $signed({2'b00, PI_Q29});
      end else begin
         s2_cor_ff.x <= dxe1;
         s2_cor_ff.y <= dye1;
         s2_cor_ff.z <= '0;
      end
   end

   // ---------------- stages 3-4: sum of squares ----------------
   logic [61:0] s3_sqx_ff;
   logic [61:0] s3_sqy_ff;
   logic [62:0] s4_sum_ff;

   always_ff @(posedge clock) begin
      s3_sqx_ff <= s2_ax_ff * s2_ax_ff;
      s3_sqy_ff <= s2_ay_ff * s2_ay_ff;
      s4_sum_ff <= {1'b0, s3_sqx_ff} + {1'b0, s3_sqy_ff};
   end

   // ---------------- stages 5-36: square root row ----------------
   sqrt_type sq_d [33];

   assign sq_d[0] = '{rad: {1'b0, s4_sum_ff}, rem: '0, root: '0};

   for (genvar j = 0; j < 32; j++) begin : g_sqrt
      asf_sqrt_cell u_cell (
         .clock  (clock),
         .sq_in  (sq_d[j]),
         .sq_out (sq_d[j+1])
      );
   end

   // ---------------- stages 3..CORDIC_STEPS+2: CORDIC row ----------------
   cordic_type cor_d [CORDIC_STEPS+1];

   assign cor_d[0] = s2_cor_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      asf_cordic_cell #(.K(i)) u_cell (
         .clock   (clock),
         .cor_in  (cor_d[i]),
         .cor_out (cor_d[i+1])
      );
   end

   // side data lined up with the root
   side_a_type      sa36;
   logic            sh36;
   logic [CZ_W-1:0] z36;

   asf_delay #(.W($bits(side_a_type)), .DEPTH(35)) u_dly_a (
      .clock (clock),
      .din   (s1_ff),
      .dout  (sa36)
   );

   asf_delay #(.W(1), .DEPTH(34)) u_dly_sh (
      .clock (clock),
      .din   (s2_sh_ff),
      .dout  (sh36)
   );

   asf_delay #(.W(CZ_W), .DEPTH(ZDLY)) u_dly_z (
      .clock (clock),
      .din   (cor_d[CORDIC_STEPS].z),
      .dout  (z36)
   );

   // ---------------- stage 37: distance, angle difference ----------------
   logic [32:0] s37_dist_ff;
   logic [47:0] s37_u_ff;
   logic        s37_zero_ff;
   side_a_type  s37_sa_ff;

   always_ff @(posedge clock) begin
      s37_dist_ff <= sh36 ? {sq_d[32].root, 1'b0} : {1'b0, sq_d[32].root};
      // heading Q16.16 to Q29 is a shift by 13
      s37_u_ff <= {{(48-CZ_W){z36[CZ_W-1]}}, z36} + MOD_BIAS
                  - {{3{sa36.head[31]}}, sa36.head, 13'd0};
      s37_zero_ff <= (sa36.dx == '0) && (sa36.dy == '0);
      s37_sa_ff <= sa36;
   end

   // ---------------- stages 38-53: reduce angle modulo 2pi ----------------
   logic [47:0] mod_rem [17];
   logic [31:0] mod_den [17];
   logic [15:0] mod_quot [17];
   logic        zero53;

   assign mod_rem[0] = s37_u_ff;
   assign mod_den[0] = TWO_PI_Q29;
   assign mod_quot[0] = '0;

   for (genvar i = 0; i < 16; i++) begin : g_mod
      asf_div_cell #(.RW(48), .DW(32), .QW(16), .K(15 - i)) u_cell (
         .clock    (clock),
         .rem_in   (mod_rem[i]),
         .den_in   (mod_den[i]),
         .quot_in  (mod_quot[i]),
         .rem_out  (mod_rem[i+1]),
         .den_out  (mod_den[i+1]),
         .quot_out (mod_quot[i+1])
      );
   end

   asf_delay #(.W(1), .DEPTH(16)) u_dly_zero (
      .clock (clock),
      .din   (s37_zero_ff),
      .dout  (zero53)
   );

   // ---------------- stage 54: turn force ----------------
   logic signed [33:0] r53;
   logic signed [33:0] rr53;
   logic signed [33:0] t53;
   logic [15:0]        s54_turn_ff;
   logic [15:0]        turn138;

   always_comb begin
      // fold [0, 2pi) into (-pi, pi]
      if (mod_rem[16][31:0] > PI_Q29) begin
         r53 = $signed({2'b00, mod_rem[16][31:0]}) - $signed({2'b00, TWO_PI_Q29});
      end else begin
         r53 = $signed({2'b00, mod_rem[16][31:0]});
      end
      // Q29 to Q3.13, round half up
      rr53 = r53 + 34'sd32768;
      t53 = rr53 >>> 16;
      if (t53 > TURN_MAX) begin
         t53 = TURN_MAX;
      end else if (t53 < -TURN_MAX) begin
         t53 = -TURN_MAX;
      end
   end

   always_ff @(posedge clock) begin
      s54_turn_ff <= zero53 ? 16'd0 : t53[15:0];
   end

   asf_delay #(.W(16), .DEPTH(84)) u_dly_turn (
      .clock (clock),
      .din   (s54_turn_ff),
      .dout  (turn138)
   );

   // ---------------- stages 38-39: stop test, wanted speed numerator ----------------
   side_c_type  s38_c_ff;
   logic [30:0] s38_diff_ff;
   logic [61:0] s39_prod_ff;

   always_ff @(posedge clock) begin
      s38_c_ff.stopped <= s37_dist_ff < {2'b00, sr_ff};
      s38_c_ff.want_big <= (s37_dist_ff > {2'b00, br_ff}) || (br_ff == '0);
      s38_c_ff.zero <= s37_zero_ff;
      s38_c_ff.sx <= s37_sa_ff.dx[32];
      s38_c_ff.sy <= s37_sa_ff.dy[32];
      s38_c_ff.mf <= s37_sa_ff.mf;
      s38_c_ff.magx <= s37_sa_ff.dx[32] ? 32'(33'd0 - s37_sa_ff.dx) : s37_sa_ff.dx[31:0];
      s38_c_ff.magy <= s37_sa_ff.dy[32] ? 32'(33'd0 - s37_sa_ff.dy) : s37_sa_ff.dy[31:0];
      s38_c_ff.vx <= s37_sa_ff.vx;
      s38_c_ff.vy <= s37_sa_ff.vy;
      s38_c_ff.dlen <= s37_dist_ff;
      // only meaningful when stop_radius <= distance <= brake_radius
      s38_diff_ff <= s37_dist_ff[30:0] - sr_ff;
      s39_prod_ff <= s38_c_ff.mf * s38_diff_ff;
   end

   // ---------------- stages 40-70: wanted speed divider ----------------
   logic [61:0] wd_rem [32];
   logic [30:0] wd_den [32];
   logic [30:0] wd_quot [32];
   side_c_type  c70;

   assign wd_rem[0] = s39_prod_ff;
   assign wd_den[0] = br_ff;
   assign wd_quot[0] = '0;

   for (genvar i = 0; i < 31; i++) begin : g_want
      asf_div_cell #(.RW(62), .DW(31), .QW(31), .K(30 - i)) u_cell (
         .clock    (clock),
         .rem_in   (wd_rem[i]),
         .den_in   (wd_den[i]),
         .quot_in  (wd_quot[i]),
         .rem_out  (wd_rem[i+1]),
         .den_out  (wd_den[i+1]),
         .quot_out (wd_quot[i+1])
      );
   end

   asf_delay #(.W($bits(side_c_type)), .DEPTH(32)) u_dly_c (
      .clock (clock),
      .din   (s38_c_ff),
      .dout  (c70)
   );

   // ---------------- stages 71-72: wanted components numerators ----------------
   logic [30:0] s71_want_ff;
   side_c_type  s71_c_ff;
   logic [62:0] s72_px_ff;
   logic [62:0] s72_py_ff;
   logic [32:0] s72_dist_ff;
   side_d_type  s72_d_ff;

   always_ff @(posedge clock) begin
      s71_want_ff <= c70.want_big ? c70.mf : wd_quot[31];
      s71_c_ff <= c70;
      s72_px_ff <= s71_c_ff.magx * s71_want_ff;
      s72_py_ff <= s71_c_ff.magy * s71_want_ff;
      s72_dist_ff <= s71_c_ff.dlen;
      s72_d_ff.sx <= s71_c_ff.sx;
      s72_d_ff.sy <= s71_c_ff.sy;
      s72_d_ff.zero <= s71_c_ff.zero;
      s72_d_ff.stopped <= s71_c_ff.stopped;
      s72_d_ff.vx <= s71_c_ff.vx;
      s72_d_ff.vy <= s71_c_ff.vy;
   end

   // ---------------- stages 73-104: divide components by distance ----------------
   logic [63:0] sx_rem [33];
   logic [32:0] sx_den [33];
   logic [31:0] sx_quot [33];
   logic [63:0] sy_rem [33];
   logic [32:0] sy_den [33];
   logic [31:0] sy_quot [33];
   side_d_type  d104;

   assign sx_rem[0] = {1'b0, s72_px_ff};
   assign sx_den[0] = s72_dist_ff;
   assign sx_quot[0] = '0;
   assign sy_rem[0] = {1'b0, s72_py_ff};
   assign sy_den[0] = s72_dist_ff;
   assign sy_quot[0] = '0;

   for (genvar i = 0; i < 32; i++) begin : g_scale
      asf_div_cell #(.RW(64), .DW(33), .QW(32), .K(31 - i)) u_cell_x (
         .clock    (clock),
         .rem_in   (sx_rem[i]),
         .den_in   (sx_den[i]),
         .quot_in  (sx_quot[i]),
         .rem_out  (sx_rem[i+1]),
         .den_out  (sx_den[i+1]),
         .quot_out (sx_quot[i+1])
      );
      asf_div_cell #(.RW(64), .DW(33), .QW(32), .K(31 - i)) u_cell_y (
         .clock    (clock),
         .rem_in   (sy_rem[i]),
         .den_in   (sy_den[i]),
         .quot_in  (sy_quot[i]),
         .rem_out  (sy_rem[i+1]),
         .den_out  (sy_den[i+1]),
         .quot_out (sy_quot[i+1])
      );
   end

   asf_delay #(.W($bits(side_d_type)), .DEPTH(32)) u_dly_d (
      .clock (clock),
      .din   (s72_d_ff),
      .dout  (d104)
   );

   // ---------------- stages 105-106: wanted minus velocity, scale, overflow ----------------
   logic signed [33:0] wx104;
   logic signed [33:0] wy104;
   logic signed [33:0] s105_fx_ff;
   logic signed [33:0] s105_fy_ff;
   logic               s105_st_ff;
   logic [32:0]        ax105;
   logic [32:0]        ay105;
   logic [63:0]        nx105;
   logic [63:0]        ny105;
   logic [30:0]        bfe;
   logic [63:0]        lim105;
   logic [63:0]        s106_nx_ff;
   logic [63:0]        s106_ny_ff;
   logic [30:0]        s106_bf_ff;
   side_e_type         s106_e_ff;

   always_comb begin
      // zero offset gives a zero wanted vector
      if (d104.zero) begin
         wx104 = '0;
         wy104 = '0;
      end else begin
         wx104 = d104.sx ? -$signed({2'b00, sx_quot[32]}) : $signed({2'b00, sx_quot[32]});
         wy104 = d104.sy ? -$signed({2'b00, sy_quot[32]}) : $signed({2'b00, sy_quot[32]});
      end
      ax105 = s105_fx_ff[33] ? 33'(-s105_fx_ff) : s105_fx_ff[32:0];
      ay105 = s105_fy_ff[33] ? 33'(-s105_fy_ff) : s105_fy_ff[32:0];
      nx105 = {15'd0, ax105, 16'd0};
      ny105 = {15'd0, ay105, 16'd0};
      // a zero brake factor acts as one LSB
      bfe = (bf_ff == '0) ? 31'd1 : bf_ff;
      lim105 = {1'b0, bfe, 32'd0};
   end

   always_ff @(posedge clock) begin
      s105_fx_ff <= wx104 - $signed({{2{d104.vx[31]}}, d104.vx});
      s105_fy_ff <= wy104 - $signed({{2{d104.vy[31]}}, d104.vy});
      s105_st_ff <= d104.stopped;
      s106_nx_ff <= nx105;
      s106_ny_ff <= ny105;
      s106_bf_ff <= bfe;
      s106_e_ff.negx <= s105_fx_ff[33];
      s106_e_ff.negy <= s105_fy_ff[33];
      s106_e_ff.ovfx <= nx105 >= lim105;
      s106_e_ff.ovfy <= ny105 >= lim105;
      s106_e_ff.stopped <= s105_st_ff;
   end

   // ---------------- stages 107-138: brake factor divider ----------------
   logic [63:0] fx_rem [33];
   logic [30:0] fx_den [33];
   logic [31:0] fx_quot [33];
   logic [63:0] fy_rem [33];
   logic [30:0] fy_den [33];
   logic [31:0] fy_quot [33];
   side_e_type  e138;

   assign fx_rem[0] = s106_nx_ff;
   assign fx_den[0] = s106_bf_ff;
   assign fx_quot[0] = '0;
   assign fy_rem[0] = s106_ny_ff;
   assign fy_den[0] = s106_bf_ff;
   assign fy_quot[0] = '0;

   for (genvar i = 0; i < 32; i++) begin : g_force
      asf_div_cell #(.RW(64), .DW(31), .QW(32), .K(31 - i)) u_cell_x (
         .clock    (clock),
         .rem_in   (fx_rem[i]),
         .den_in   (fx_den[i]),
         .quot_in  (fx_quot[i]),
         .rem_out  (fx_rem[i+1]),
         .den_out  (fx_den[i+1]),
         .quot_out (fx_quot[i+1])
      );
      asf_div_cell #(.RW(64), .DW(31), .QW(32), .K(31 - i)) u_cell_y (
         .clock    (clock),
         .rem_in   (fy_rem[i]),
         .den_in   (fy_den[i]),
         .quot_in  (fy_quot[i]),
         .rem_out  (fy_rem[i+1]),
         .den_out  (fy_den[i+1]),
         .quot_out (fy_quot[i+1])
      );
   end

   asf_delay #(.W($bits(side_e_type)), .DEPTH(32)) u_dly_e (
      .clock (clock),
      .din   (s106_e_ff),
      .dout  (e138)
   );

   // ---------------- stage 139: result registers ----------------
   logic [31:0] rsp_force_x_ff;
   logic [31:0] rsp_force_y_ff;
   logic [15:0] rsp_turn_ff;
   logic        rsp_stopped_ff;

   always_ff @(posedge clock) begin
      // inside the stop radius both forces and the turn force are forced to zero
      if (e138.stopped) begin
         rsp_force_x_ff <= '0;
         rsp_force_y_ff <= '0;
         rsp_turn_ff <= '0;
      end else begin
         rsp_force_x_ff <= sat_force(e138.negx, e138.ovfx, fx_quot[32]);
         rsp_force_y_ff <= sat_force(e138.negy, e138.ovfy, fy_quot[32]);
         rsp_turn_ff <= turn138;
      end
      rsp_stopped_ff <= e138.stopped;
   end

   assign rsp_force_x = $signed(rsp_force_x_ff);
   assign rsp_force_y = $signed(rsp_force_y_ff);
   assign rsp_turn_force = $signed(rsp_turn_ff);
   assign rsp_stopped = rsp_stopped_ff;

endmodule

// File: dv/testbench.sv
// Testbench of the arrive steering force block: directed and random agent items.
module testbench;
   import asf_pkg::*;

   // ---------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_target_x;
   logic signed [31:0] req_target_y;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic signed [31:0] req_heading;
   logic signed [31:0] req_vel_x;
   logic signed [31:0] req_vel_y;
   logic [30:0]        req_max_force;
   logic               rsp_valid;
   logic signed [31:0] rsp_force_x;
   logic signed [31:0] rsp_force_y;
   logic signed [15:0] rsp_turn_force;
   logic               rsp_stopped;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [30:0]        csr_wdata;

   localparam int WATCHDOG_LIMIT = 4 * LATENCY + 2000;

   arrive_steering_force uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_heading(req_heading),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_max_force(req_max_force),
      .rsp_valid(rsp_valid), .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y),
      .rsp_turn_force(rsp_turn_force), .rsp_stopped(rsp_stopped),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the three radius/factor registers
   // ---------------------------------------------------------------------
   typedef struct {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [15:0] turn_force;
      logic               stopped;
   } steer_result_t;

   logic [30:0] brake_radius_q;
   logic [30:0] stop_radius_q;
   logic [30:0] brake_factor_q;

   steer_result_t expected_steer[$];
   int mismatch_count;
   int quiet_cycles;
   bit timed_out;

   // arctan(2^-i) in Q29, same constants as ATAN_Q29 in asf_pkg
   function automatic longint atan_step(int i);
      longint tab[24] = '{421657428, 248918915, 131521918, 66762579, 33510830,
         16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072,
         65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
      return tab[i];
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // vectoring CORDIC, Q29 result in (-pi-ish, pi-ish]
   function automatic longint bearing_q29(longint x, longint y);
      longint z, nx;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(PI_Q29) : -longint'(PI_Q29);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
         // arithmetic shift of a signed value floors, as required
         if (y > 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wanted_component(longint d, longint unsigned want,
                                               longint unsigned dlen);
      longint unsigned mag, q;
      if (dlen == 0) return 0;
      mag = (d < 0) ? -d : d;
      q = (mag * want) / dlen;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic steer_result_t arrive_force(
      logic signed [31:0] tx, logic signed [31:0] ty, logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] hd, logic signed [31:0] vx,
      logic signed [31:0] vy, logic [30:0] mf);
      steer_result_t r;
      longint dx, dy, ang, turn;
      longint unsigned ax, ay, dlen, want, bf;
      longint fx, fy;
      int sh;
      dx = longint'(tx) - longint'(px);
      dy = longint'(ty) - longint'(py);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sh = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 1 : 0;
      ax >>= sh;
      ay >>= sh;
      dlen = int_root(ax * ax + ay * ay) << sh;
      r = '{force_x: 0, force_y: 0, turn_force: 0, stopped: 1'b1};
      if (dlen < stop_radius_q) return r;
      if (dx == 0 && dy == 0) begin
         turn = 0;
      end else begin
         ang = (bearing_q29(dx, dy) - longint'(hd) * 8192) % longint'(TWO_PI_Q29);
         if (ang < 0) ang += longint'(TWO_PI_Q29);
         if (ang > longint'(PI_Q29)) ang -= longint'(TWO_PI_Q29);
         // round half up to Q3.13
         turn = ((ang + 64'sd4294967296 + 32768) >>> 16) - 65536;
         if (turn > 25736) turn = 25736;
         if (turn < -25736) turn = -25736;
      end
      if (dlen > brake_radius_q || brake_radius_q == 0)
         want = mf;
      else
         want = (longint'(mf) * (dlen - stop_radius_q)) / brake_radius_q;
      bf = (brake_factor_q == 0) ? 1 : brake_factor_q;
      fx = ((wanted_component(dx, want, dlen) - longint'(vx)) * 65536) / longint'(bf);
      fy = ((wanted_component(dy, want, dlen) - longint'(vy)) * 65536) / longint'(bf);
      r.force_x = clamp32(fx);
      r.force_y = clamp32(fy);
      r.turn_force = turn[15:0];
      r.stopped = 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every strobe must match the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      steer_result_t e;
      if (!reset && rsp_valid) begin
         if (expected_steer.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result fx=%0d fy=%0d turn=%0d stop=%0d",
                        rsp_force_x, rsp_force_y, rsp_turn_force, rsp_stopped);
         end else begin
            e = expected_steer.pop_front();
            if (rsp_force_x !== e.force_x || rsp_force_y !== e.force_y ||
                rsp_turn_force !== e.turn_force || rsp_stopped !== e.stopped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp fx=%0d fy=%0d turn=%0d stop=%0d | got %0d %0d %0d %0d",
                           e.force_x, e.force_y, e.turn_force, e.stopped,
                           rsp_force_x, rsp_force_y, rsp_turn_force, rsp_stopped);
            end
         end
      end
   end

   // watchdog: cycles with no item accepted and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   int burst_left;

   // bursty sender: random gaps before a new burst
   task automatic send_agent(logic signed [31:0] tx, logic signed [31:0] ty,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] hd, logic signed [31:0] vx,
                             logic signed [31:0] vy, logic [30:0] mf);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (start) begin
            start <= 1'b0;
            @(negedge clock);
            gap = (gap > 0) ? gap - 1 : 0;
         end
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      start <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= hd;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_max_force <= mf;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_steer.push_back(arrive_force(tx, ty, px, py, hd, vx, vy, mf));
      @(negedge clock);
   endtask

   // drain the pipeline so register writes never hit an item in flight
   task automatic wait_idle();
      if (start) start <= 1'b0;
      while (expected_steer.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(csr_index_type idx, logic [30:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BRAKE_RADIUS: brake_radius_q = value;
         CSR_STOP_RADIUS:  stop_radius_q = value;
         default:          brake_factor_q = value;
      endcase
   endtask

   task automatic set_regs(logic [30:0] br, logic [30:0] sr, logic [30:0] bf);
      wait_idle();
      write_reg(CSR_BRAKE_RADIUS, br);
      write_reg(CSR_STOP_RADIUS, sr);
      write_reg(CSR_BRAKE_FACTOR, bf);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
         2: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
         default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
   endfunction

   // random agents, offsets from four fixed ranges, one in eight of them zero
   task automatic random_agents(int count);
      logic signed [31:0] px, py, ox, oy;
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 3);
         px = rand_coord($urandom_range(0, 3));
         py = rand_coord($urandom_range(0, 3));
         ox = rand_coord(mode);
         oy = rand_coord(mode);
         if ($urandom_range(0, 7) == 0) begin
            ox = 0;
            oy = 0;
         end
         send_agent(px + ox, py + oy, px, py, $urandom(),
                    ($urandom_range(0, 1) ? $urandom() : rand_coord(1)),
                    ($urandom_range(0, 1) ? $urandom() : rand_coord(1)),
                    ($urandom_range(0, 1) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 23))));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_extremes();
      localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
      localparam logic signed [31:0] MINV = 32'sh8000_0000;
      send_agent(0, 0, 0, 0, 0, 0, 0, 0);                          // zero offset, stopped
      send_agent(MAXV, MAXV, MINV, MINV, MAXV, MAXV, MINV, 31'h7FFF_FFFF);
      send_agent(MINV, MINV, MAXV, MAXV, MINV, MINV, MAXV, 31'h7FFF_FFFF);
      send_agent(MINV, 0, MAXV, 0, 0, 0, 0, 31'h7FFF_FFFF);       // -x axis, angle pi
      send_agent(MINV, -1, MAXV, 0, 0, 0, 0, 1);                   // just below -x axis
      send_agent(32'sd6553600, 0, 0, 0, 0, 0, 0, 32'sd65536);     // right on brake radius
      send_agent(32'sd655360, 0, 0, 0, 0, 0, 0, 32'sd65536);      // right on stop radius
      send_agent(32'sd655359, 0, 0, 0, 0, 0, 0, 32'sd65536);      // just inside stop
      send_agent(0, 32'sd3276800, 0, 0, 32'sd102944, 5, -5, 32'sd131072);
      send_agent(-32'sd3276800, -32'sd3276800, 0, 0, -32'sd205887, 0, 0, 32'sd131072);
      send_agent(32'sd100000000, 0, 0, 0, 32'sd205888, MINV, MAXV, 0);
   endtask

   task automatic test_zero_radii();
      // zero brake radius skips the division, zero brake factor saturates
      set_regs(31'd0, 31'd0, 31'd0);
      send_agent(0, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF);
      send_agent(32'sd1000, 32'sd1000, 0, 0, 0, 0, 0, 31'h7FFF_FFFF);
      send_agent(-32'sd1, 0, 0, 0, 0, 32'sd1, -32'sd1, 31'd5);
      random_agents(150);
   endtask

   task automatic test_max_radii();
      set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_agent(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 0, 0, 31'h7FFF_FFFF);
      random_agents(200);
      set_regs(31'h7FFF_FFFF, 31'd0, 31'd1);
      random_agents(200);
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 6; p++) begin
         set_regs($urandom_range(1, 1 << 26), $urandom_range(0, 1 << 22),
                  $urandom_range(1, 1 << 20));
         random_agents(200);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_BRAKE_RADIUS;
      csr_wdata = '0;
      req_target_x = '0;
      req_target_y = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_heading = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_max_force = '0;
      mismatch_count = 0;
      quiet_cycles = 0;
      timed_out = 1'b0;
      burst_left = 0;
      brake_radius_q = BRAKE_RADIUS_RST;
      stop_radius_q = STOP_RADIUS_RST;
      brake_factor_q = BRAKE_FACTOR_RST;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extremes();
      random_agents(200);         // reset register values
      test_zero_radii();
      test_max_radii();
      test_random_settings();

      wait_idle();
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
